// ===== rtl/rpa_pkg.sv =====
// rotate-point-about-axis package: widths, fixed-point constants, arctangent table
// and the side-band record that travels down the pipeline. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

    // configuration of the datapath
    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // arctangent table depth, more iterations than this act as this many
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    // angle is Q2.(ANGLE_WIDTH-3), the cordic runs in Q.30
    localparam int ANG_FRAC  = ANGLE_WIDTH - 3;
    localparam int ANG_SHIFT = 30 - ANG_FRAC;
    localparam int Q_SHIFT   = 30;

    // internal widths
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int CW         = 34;
    localparam int COEF_WIDTH = 32;
    localparam int PROD_WIDTH = DIFF_WIDTH + COEF_WIDTH;
    localparam int RND_WIDTH  = PROD_WIDTH - Q_SHIFT;
    localparam int SUM_WIDTH  = RND_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [CW-1:0]          t_cw;
    typedef logic signed [COEF_WIDTH-1:0]  t_coef;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [RND_WIDTH-1:0]   t_rnd;
    typedef logic signed [SUM_WIDTH-1:0]   t_sum;

    // axis codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // cordic gain compensation and half-turn constants, Q.30
    localparam t_cw CORDIC_K    = 34'sh26DD3B6A;
    localparam t_cw PI_Q30      = 34'sd3373259426;
    localparam t_cw HALF_PI_Q30 = 34'sd1686629713;
    localparam t_cw NEG_HALF_PI = -HALF_PI_Q30;

    // round to nearest, ties away from zero, after the Q.30 product
    localparam t_prod RND_POS = t_prod'(64'd536870912);
    localparam t_prod RND_NEG = RND_POS - t_prod'(1);

    // truncated Q.30 arctangent of 2^-i
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // per-transaction record carried alongside the cordic
    typedef struct packed {
        t_axis  axis;
        logic   bypass;
        logic   flip;
        t_coord px;
        t_coord py;
        t_coord pz;
        t_coord ca;
        t_coord cb;
        t_diff  da;
        t_diff  db;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/rpa_if.sv =====
// valid/ready channel interfaces for the point rotation unit.
// depends on rpa_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface rpa_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           axis;
    rpa_pkg::t_coord      point_x;
    rpa_pkg::t_coord      point_y;
    rpa_pkg::t_coord      point_z;
    rpa_pkg::t_coord      center_x;
    rpa_pkg::t_coord      center_y;
    rpa_pkg::t_coord      center_z;
    rpa_pkg::t_angle      angle;

    modport source (
        output valid, axis, point_x, point_y, point_z,
        output center_x, center_y, center_z, angle,
        input  ready
    );
    modport sink (
        input  valid, axis, point_x, point_y, point_z,
        input  center_x, center_y, center_z, angle,
        output ready
    );
endinterface

interface rpa_out_if;
    logic            valid;
    logic            ready;
    rpa_pkg::t_coord out_x;
    rpa_pkg::t_coord out_y;
    rpa_pkg::t_coord out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpa_prep.sv =====
// input stage: offsets from the centre, axis operand select, angle scaling
// and half-turn reduction. depends on rpa_pkg and rpa_if.
`timescale 1ns / 1ps
`default_nettype none

module rpa_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rpa_in_if.sink             i_in,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rpa_pkg::t_side     o_side,
    output rpa_pkg::t_cw       o_z
);

    logic            r_valid;
    rpa_pkg::t_side  r_side;
    rpa_pkg::t_cw    r_z;
    rpa_pkg::t_side  n_side;
    rpa_pkg::t_cw    n_z;
    rpa_pkg::t_cw    z_scaled;
    rpa_pkg::t_axis  axis;
    logic            en;

    function automatic rpa_pkg::t_diff diff(input rpa_pkg::t_coord p, input rpa_pkg::t_coord c);
        return rpa_pkg::t_diff'(p) - rpa_pkg::t_diff'(c);
    endfunction

    assign axis     = rpa_pkg::t_axis'(i_in.axis);
    assign z_scaled = rpa_pkg::t_cw'(i_in.angle) <<< rpa_pkg::ANG_SHIFT;

    // stage advances when empty or when the next stage takes its contents
    assign en         = !r_valid || i_ready;
    assign i_in.ready = en;

    // angle reduction into the cordic convergence range
    always_comb begin
        n_side        = '0;
        n_side.axis   = axis;
        n_side.bypass = (axis == rpa_pkg::AXIS_NONE) || (i_in.angle == '0);
        n_side.px     = i_in.point_x;
        n_side.py     = i_in.point_y;
        n_side.pz     = i_in.point_z;
        n_z           = z_scaled;
        priority if (z_scaled > rpa_pkg::HALF_PI_Q30) begin
            n_z         = z_scaled - rpa_pkg::PI_Q30;
            n_side.flip = 1'b1;
        end else if (z_scaled < rpa_pkg::NEG_HALF_PI) begin
            n_z         = z_scaled + rpa_pkg::PI_Q30;
            n_side.flip = 1'b1;
        end else begin
            n_side.flip = 1'b0;
        end

        // pick the two coordinates in the rotation plane
        unique case (axis)
            rpa_pkg::AXIS_X: begin
                n_side.ca = i_in.center_y;
                n_side.cb = i_in.center_z;
                n_side.da = diff(i_in.point_y, i_in.center_y);
                n_side.db = diff(i_in.point_z, i_in.center_z);
            end
            rpa_pkg::AXIS_Y: begin
                n_side.ca = i_in.center_x;
                n_side.cb = i_in.center_z;
                n_side.da = diff(i_in.point_x, i_in.center_x);
                n_side.db = diff(i_in.point_z, i_in.center_z);
            end
            rpa_pkg::AXIS_Z, rpa_pkg::AXIS_NONE: begin
                n_side.ca = i_in.center_x;
                n_side.cb = i_in.center_y;
                n_side.da = diff(i_in.point_x, i_in.center_x);
                n_side.db = diff(i_in.point_y, i_in.center_y);
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_in.valid;
        end
        if (en) begin
            r_side <= n_side;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_z     = r_z;

endmodule

`default_nettype wire

// ===== rtl/rpa_cordic.sv =====
// rotation-mode cordic, one registered iteration per stage, producing
// cosine and sine in Q.30. depends on rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_cordic (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire rpa_pkg::t_side  i_side,
    input  wire rpa_pkg::t_cw    i_z,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output rpa_pkg::t_side       o_side,
    output rpa_pkg::t_cw         o_x,
    output rpa_pkg::t_cw         o_y
);

    localparam int N = rpa_pkg::CORDIC_N;

    logic            r_valid [N];
    rpa_pkg::t_side  r_side  [N];
    rpa_pkg::t_cw    r_x     [N];
    rpa_pkg::t_cw    r_y     [N];
    rpa_pkg::t_cw    r_z     [N-1];
    logic [N:0]      en;

    assign en[N] = i_ready;

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic            v_in;
        rpa_pkg::t_side  s_in;
        rpa_pkg::t_cw    x_in;
        rpa_pkg::t_cw    y_in;
        rpa_pkg::t_cw    z_in;
        rpa_pkg::t_cw    n_x;
        rpa_pkg::t_cw    n_y;
        logic            rot_pos;

        // stage inputs: seed vector at the head, previous stage otherwise
        if (g == 0) begin : g_head
            assign v_in = i_valid;
            assign s_in = i_side;
            assign x_in = rpa_pkg::CORDIC_K;
            assign y_in = '0;
            assign z_in = i_z;
        end else begin : g_body
            assign v_in = r_valid[g-1];
            assign s_in = r_side[g-1];
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
        end

        // micro-rotation toward zero residual angle
        assign rot_pos = !z_in[rpa_pkg::CW-1];
        assign n_x     = rot_pos ? (x_in - (y_in >>> g)) : (x_in + (y_in >>> g));
        assign n_y     = rot_pos ? (y_in + (x_in >>> g)) : (y_in - (x_in >>> g));

        assign en[g] = !r_valid[g] || en[g+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (en[g]) begin
                r_valid[g] <= v_in;
            end
            if (en[g]) begin
                r_side[g] <= s_in;
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
            end
        end

        // residual angle, not needed after the last iteration
        if (g < N - 1) begin : g_zreg
            rpa_pkg::t_cw atan_v;
            rpa_pkg::t_cw n_z;

            assign atan_v = rpa_pkg::t_cw'(rpa_pkg::ATAN_TAB[g]);
            assign n_z    = rot_pos ? (z_in - atan_v) : (z_in + atan_v);

            always_ff @(posedge i_clk) begin
                if (en[g]) begin
                    r_z[g] <= n_z;
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[N-1];
    assign o_side  = r_side[N-1];
    assign o_x     = r_x[N-1];
    assign o_y     = r_y[N-1];

endmodule

`default_nettype wire

// ===== rtl/rpa_mul.sv =====
// coefficient sign fix-up and the four offset-by-coefficient products,
// two register stages. depends on rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_mul (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire rpa_pkg::t_side  i_side,
    input  wire rpa_pkg::t_cw    i_x,
    input  wire rpa_pkg::t_cw    i_y,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output rpa_pkg::t_side       o_side,
    output rpa_pkg::t_prod       o_p_ac,
    output rpa_pkg::t_prod       o_p_bs,
    output rpa_pkg::t_prod       o_p_as,
    output rpa_pkg::t_prod       o_p_bc
);

    logic            r_cf_valid;
    rpa_pkg::t_side  r_cf_side;
    rpa_pkg::t_coef  r_c;
    rpa_pkg::t_coef  r_s;
    logic            r_mp_valid;
    rpa_pkg::t_side  r_mp_side;
    rpa_pkg::t_prod  r_p_ac;
    rpa_pkg::t_prod  r_p_bs;
    rpa_pkg::t_prod  r_p_as;
    rpa_pkg::t_prod  r_p_bc;

    rpa_pkg::t_cw    n_c_full;
    rpa_pkg::t_cw    n_s_full;
    rpa_pkg::t_prod  n_p_ac;
    rpa_pkg::t_prod  n_p_bs;
    rpa_pkg::t_prod  n_p_as;
    rpa_pkg::t_prod  n_p_bc;
    logic            neg_s;
    logic            en_cf;
    logic            en_mp;

    assign en_mp   = !r_mp_valid || i_ready;
    assign en_cf   = !r_cf_valid || en_mp;
    assign o_ready = en_cf;

    // half-turn flip negates both; rotation about y also swaps the sine sign
    assign neg_s    = i_side.flip ^ (i_side.axis == rpa_pkg::AXIS_Y);
    assign n_c_full = i_side.flip ? -i_x : i_x;
    assign n_s_full = neg_s ? -i_y : i_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf_valid <= 1'b0;
        end else if (en_cf) begin
            r_cf_valid <= i_valid;
        end
        if (en_cf) begin
            r_cf_side <= i_side;
            r_c       <= rpa_pkg::t_coef'(n_c_full);
            r_s       <= rpa_pkg::t_coef'(n_s_full);
        end
    end

    // products in the rotation plane, full width
    assign n_p_ac = r_cf_side.da * r_c;
    assign n_p_bs = r_cf_side.db * r_s;
    assign n_p_as = r_cf_side.da * r_s;
    assign n_p_bc = r_cf_side.db * r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp_valid <= 1'b0;
        end else if (en_mp) begin
            r_mp_valid <= r_cf_valid;
        end
        if (en_mp) begin
            r_mp_side <= r_cf_side;
            r_p_ac    <= n_p_ac;
            r_p_bs    <= n_p_bs;
            r_p_as    <= n_p_as;
            r_p_bc    <= n_p_bc;
        end
    end

    assign o_valid = r_mp_valid;
    assign o_side  = r_mp_side;
    assign o_p_ac  = r_p_ac;
    assign o_p_bs  = r_p_bs;
    assign o_p_as  = r_p_as;
    assign o_p_bc  = r_p_bc;

endmodule

`default_nettype wire

// ===== rtl/rpa_sum.sv =====
// product rounding, recentring, saturation and output register.
// depends on rpa_pkg and rpa_if.
`timescale 1ns / 1ps
`default_nettype none

module rpa_sum (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire rpa_pkg::t_side  i_side,
    input  wire rpa_pkg::t_prod  i_p_ac,
    input  wire rpa_pkg::t_prod  i_p_bs,
    input  wire rpa_pkg::t_prod  i_p_as,
    input  wire rpa_pkg::t_prod  i_p_bc,
    rpa_out_if.source            o_out
);

    localparam rpa_pkg::t_sum SAT_HI =
        rpa_pkg::t_sum'({1'b0, {(rpa_pkg::COORD_WIDTH-1){1'b1}}});
    localparam rpa_pkg::t_sum SAT_LO = -SAT_HI - rpa_pkg::t_sum'(1);

    logic            r_rd_valid;
    rpa_pkg::t_side  r_rd_side;
    rpa_pkg::t_rnd   r_q_ac;
    rpa_pkg::t_rnd   r_q_bs;
    rpa_pkg::t_rnd   r_q_as;
    rpa_pkg::t_rnd   r_q_bc;
    logic            r_valid;
    rpa_pkg::t_coord r_x;
    rpa_pkg::t_coord r_y;
    rpa_pkg::t_coord r_z;

    rpa_pkg::t_sum   sum_a;
    rpa_pkg::t_sum   sum_b;
    rpa_pkg::t_coord ra;
    rpa_pkg::t_coord rb;
    rpa_pkg::t_coord n_x;
    rpa_pkg::t_coord n_y;
    rpa_pkg::t_coord n_z;
    logic            en_rd;
    logic            en_out;

    // round to nearest with ties away from zero
    function automatic rpa_pkg::t_rnd rnd(input rpa_pkg::t_prod p);
        rpa_pkg::t_prod biased;
        biased = p + (p[rpa_pkg::PROD_WIDTH-1] ? rpa_pkg::RND_NEG : rpa_pkg::RND_POS);
        return rpa_pkg::t_rnd'(biased >>> rpa_pkg::Q_SHIFT);
    endfunction

    function automatic rpa_pkg::t_coord sat(input rpa_pkg::t_sum v);
        rpa_pkg::t_sum c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return rpa_pkg::t_coord'(c);
    endfunction

    assign en_out      = !r_valid || o_out.ready;
    assign en_rd       = !r_rd_valid || en_out;
    assign o_ready     = en_rd;

    // rounding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (en_rd) begin
            r_rd_valid <= i_valid;
        end
        if (en_rd) begin
            r_rd_side <= i_side;
            r_q_ac    <= rnd(i_p_ac);
            r_q_bs    <= rnd(i_p_bs);
            r_q_as    <= rnd(i_p_as);
            r_q_bc    <= rnd(i_p_bc);
        end
    end

    // recentre and saturate the two plane coordinates
    assign sum_a = rpa_pkg::t_sum'(r_rd_side.ca) + rpa_pkg::t_sum'(r_q_ac)
                 - rpa_pkg::t_sum'(r_q_bs);
    assign sum_b = rpa_pkg::t_sum'(r_rd_side.cb) + rpa_pkg::t_sum'(r_q_as)
                 + rpa_pkg::t_sum'(r_q_bc);
    assign ra    = sat(sum_a);
    assign rb    = sat(sum_b);

    // place results back by axis, point passes through when not rotated
    always_comb begin
        n_x = r_rd_side.px;
        n_y = r_rd_side.py;
        n_z = r_rd_side.pz;
        if (!r_rd_side.bypass) begin
            unique case (r_rd_side.axis)
                rpa_pkg::AXIS_X: begin
                    n_y = ra;
                    n_z = rb;
                end
                rpa_pkg::AXIS_Y: begin
                    n_x = ra;
                    n_z = rb;
                end
                rpa_pkg::AXIS_Z: begin
                    n_x = ra;
                    n_y = rb;
                end
                rpa_pkg::AXIS_NONE: begin
                    n_x = r_rd_side.px;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en_out) begin
            r_valid <= r_rd_valid;
        end
        if (en_out) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.out_x = r_x;
    assign o_out.out_y = r_y;
    assign o_out.out_z = r_z;

endmodule

`default_nettype wire

// ===== rtl/rotate_point_about_axis_unit.sv =====
// rotate a point about a centre around the x, y or z axis, top level.
// stages from input transaction to result: 1 input, 16 cordic, 2 multiply,
// 2 round/sum; throughput: one transaction per cycle unless output stalls.
// every stage has its own valid bit, so bubbles close up under back-pressure.
// reset (synchronous, active low) clears only the valid bits; no other state.
// depends on rpa_pkg, rpa_if, rpa_prep, rpa_cordic, rpa_mul, rpa_sum.
`timescale 1ns / 1ps
`default_nettype none

module rotate_point_about_axis_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rpa_in_if.sink     i_in,
    rpa_out_if.source  o_out
);

    // input stage to cordic
    logic            pr_valid;
    logic            pr_ready;
    rpa_pkg::t_side  pr_side;
    rpa_pkg::t_cw    pr_z;

    // cordic to multiply
    logic            co_valid;
    logic            co_ready;
    rpa_pkg::t_side  co_side;
    rpa_pkg::t_cw    co_x;
    rpa_pkg::t_cw    co_y;

    // multiply to sum
    logic            mu_valid;
    logic            mu_ready;
    rpa_pkg::t_side  mu_side;
    rpa_pkg::t_prod  mu_p_ac;
    rpa_pkg::t_prod  mu_p_bs;
    rpa_pkg::t_prod  mu_p_as;
    rpa_pkg::t_prod  mu_p_bc;

    rpa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (pr_valid),
        .i_ready (pr_ready),
        .o_side  (pr_side),
        .o_z     (pr_z)
    );

    rpa_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pr_valid),
        .o_ready (pr_ready),
        .i_side  (pr_side),
        .i_z     (pr_z),
        .o_valid (co_valid),
        .i_ready (co_ready),
        .o_side  (co_side),
        .o_x     (co_x),
        .o_y     (co_y)
    );

    rpa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (co_valid),
        .o_ready (co_ready),
        .i_side  (co_side),
        .i_x     (co_x),
        .i_y     (co_y),
        .o_valid (mu_valid),
        .i_ready (mu_ready),
        .o_side  (mu_side),
        .o_p_ac  (mu_p_ac),
        .o_p_bs  (mu_p_bs),
        .o_p_as  (mu_p_as),
        .o_p_bc  (mu_p_bc)
    );

    rpa_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mu_valid),
        .o_ready (mu_ready),
        .i_side  (mu_side),
        .i_p_ac  (mu_p_ac),
        .i_p_bs  (mu_p_bs),
        .i_p_as  (mu_p_as),
        .i_p_bc  (mu_p_bc),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
